// ===== rtl/core/separable_binomial_blur_defines.svh =====
// Assertion macros used by the blur checker.
`ifndef SEPARABLE_BINOMIAL_BLUR_DEFINES_SVH
`define SEPARABLE_BINOMIAL_BLUR_DEFINES_SVH

// ante holds at one edge -> cons holds at the next edge, masked during reset
`define SBB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// checks the state that reset leaves behind, so not masked by reset
`define SBB_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sbb_pkg.sv =====
package sbb_pkg;

   localparam int PIX_W        = 8;
   localparam int COL_OUT_W    = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 1;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int WIDTH_RESET   = 1024;
   localparam int HEIGHT_RESET  = 1024;

   // results one transaction can cause, and the counter that tracks them
   localparam int OB_DEPTH  = 4;
   localparam int OB_IDX_W  = 2;
   localparam int OB_CNT_W  = 3;

   // one line store entry: {row before last, last row}
   localparam int PAIR_W = 2 * PIX_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [PIX_W-1:0]     pixel;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
   } result_type;

endpackage

// ===== rtl/core/sbb_line_bank.sv =====
// One bank of the line store: one write and one registered read per cycle.
module sbb_line_bank #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [sbb_pkg::PAIR_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [sbb_pkg::PAIR_W-1:0] rd_data_ff
);

   logic [sbb_pkg::PAIR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/separable_binomial_blur.sv =====
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+---------------------------------------------
// req      | in  | req_valid / req_ready | req_pixel_in
// rsp      | out | rsp_valid / rsp_ready | rsp_pixel_out, rsp_out_col, rsp_out_row,
//          |     |                       | rsp_run_last
// csr      | in  | csr_we                | csr_addr, csr_wdata
//
// One transaction per cycle in while req is not stalled; its first result reaches rsp
// through stage 1, then the result buffer.
// A transaction causing k results (0, 1, 2 or 4) holds the result buffer until all k
// are taken; 2-result bursts (every column of the bottom row, row ends) and the
// 4-result burst at the bottom row end can stall req while they drain. Throughput is
// set by the single 4-entry result buffer, drained one per cycle while rsp_ready holds.
// Synchronous reset clears counters, pixel history and all valid state; the
// line stores are not cleared and need no clearing pass.
module separable_binomial_blur #(
   parameter int MAX_WIDTH = sbb_pkg::MAX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sbb_pkg::PIX_W-1:0]        req_pixel_in,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sbb_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic [sbb_pkg::COL_OUT_W-1:0]    rsp_out_col,
   output logic [sbb_pkg::ROW_W-1:0]        rsp_out_row,
   output logic                             rsp_run_last,

   input  logic                             csr_we,
   input  logic [sbb_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [sbb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ColW       = $clog2(MAX_WIDTH);
   localparam int ColExtW    = (ColW > sbb_pkg::COL_OUT_W) ? ColW : sbb_pkg::COL_OUT_W;
   localparam int WcmpRaw    = $clog2(MAX_WIDTH + 1);
   localparam int WcmpW      = (WcmpRaw > sbb_pkg::WIDTH_REG_W) ? WcmpRaw
                                                                 : sbb_pkg::WIDTH_REG_W;
   localparam int BankDepth  = (MAX_WIDTH + 1) / 2;
   localparam int BankAw     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
   localparam int WidthLastReset =
      ((sbb_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : sbb_pkg::WIDTH_RESET) - 1;
   localparam int HeightLastReset = sbb_pkg::HEIGHT_RESET - 1;

   // ---------------------------------------------------------------- arithmetic
   // top row: rounded 2-tap; inner rows: rounded [1 2 1]
   function automatic logic [sbb_pkg::PIX_W-1:0] vert_upper(
      input logic [sbb_pkg::PIX_W-1:0] a,
      input logic [sbb_pkg::PIX_W-1:0] b,
      input logic [sbb_pkg::PIX_W-1:0] q,
      input logic                      top
   );
      logic [9:0] s3;
      logic [8:0] s2;
      s3 = 10'(a) + 10'({b, 1'b0}) + 10'(q) + 10'd2;
      s2 = 9'(b) + 9'(q) + 9'd1;
      return top ? s2[8:1] : s3[9:2];
   endfunction

   // bottom row: truncated 2-tap
   function automatic logic [sbb_pkg::PIX_W-1:0] vert_bottom(
      input logic [sbb_pkg::PIX_W-1:0] b,
      input logic [sbb_pkg::PIX_W-1:0] q
   );
      logic [8:0] s2;
      s2 = 9'(b) + 9'(q);
      return s2[8:1];
   endfunction

   // ---------------------------------------------------------------- config
   // Stored as clamped "last index" values so the hot path is one compare.
   logic [ColW-1:0]            width_last_ff, width_last_in;
   logic [sbb_pkg::ROW_W-1:0]  height_last_ff, height_last_in;
   logic [WcmpW-1:0]           wv_ext, wv_m1;
   logic [sbb_pkg::HEIGHT_REG_W-1:0] hv, hv_m1;

   always_comb begin
      wv_ext = WcmpW'(csr_wdata[sbb_pkg::WIDTH_REG_W-1:0]);
      wv_m1  = wv_ext - WcmpW'(1);
      if (wv_ext < WcmpW'(2)) begin
         width_last_in = ColW'(1);
      end else if (wv_ext > WcmpW'(MAX_WIDTH)) begin
         width_last_in = ColW'(MAX_WIDTH - 1);
      end else begin
         width_last_in = wv_m1[ColW-1:0];
      end

      hv    = csr_wdata[sbb_pkg::HEIGHT_REG_W-1:0];
      hv_m1 = hv - sbb_pkg::HEIGHT_REG_W'(1);
      if (hv < sbb_pkg::HEIGHT_REG_W'(2)) begin
         height_last_in = sbb_pkg::ROW_W'(1);
      end else if (hv > sbb_pkg::HEIGHT_REG_W'(sbb_pkg::HEIGHT_LIMIT)) begin
         height_last_in = sbb_pkg::ROW_W'(sbb_pkg::HEIGHT_LIMIT - 1);
      end else begin
         height_last_in = hv_m1[sbb_pkg::ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= ColW'(WidthLastReset);
         height_last_ff <= sbb_pkg::ROW_W'(HeightLastReset);
      end else if (csr_we) begin
         case (csr_addr)
            sbb_pkg::CSR_WIDTH: begin
               width_last_ff <= width_last_in;
            end
            sbb_pkg::CSR_HEIGHT: begin
               height_last_ff <= height_last_in;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 0
   // Raster position and pixel history advance on every accepted transaction.
   logic                      req_fire;
   logic [ColW-1:0]           col_ff, col_in, col_m1;
   logic [sbb_pkg::ROW_W-1:0] row_ff, row_in;
   logic [sbb_pkg::PIX_W-1:0] prev1_ff, prev2_ff;
   logic                      last_col, last_row;

   assign req_fire = req_valid && req_ready;
   assign last_col = (col_ff >= width_last_ff);
   assign last_row = (row_ff >= height_last_ff);
   assign col_m1   = col_ff - ColW'(1);

   always_comb begin
      col_in = col_ff + ColW'(1);
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + sbb_pkg::ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prev1_ff <= '0;
         prev2_ff <= '0;
      end else if (req_fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         prev1_ff <= req_pixel_in;
         prev2_ff <= prev1_ff;
      end
   end

   // Line store split by column parity: columns c-1 and c always fall in
   // different banks, so each bank sees one read and one write per cycle.
   // Stage 1 writes c-2 (and c-1 only at a row end, when the next read is
   // unused), so the reads here never meet a pending write.
   logic [BankAw-1:0]          rd_addr0, rd_addr1;
   logic [sbb_pkg::PAIR_W-1:0] rd_data0, rd_data1;

   assign rd_addr0 = col_ff[0] ? BankAw'(col_m1 >> 1) : BankAw'(col_ff >> 1);
   assign rd_addr1 = col_ff[0] ? BankAw'(col_ff >> 1) : BankAw'(col_m1 >> 1);

   // ---------------------------------------------------------------- stage 1
   logic                      s1_valid_ff;
   logic [sbb_pkg::PIX_W-1:0] s1_pix_ff, s1_prev1_ff, s1_prev2_ff;
   logic [ColW-1:0]           s1_col_ff;
   logic [sbb_pkg::ROW_W-1:0] s1_row_ff;
   logic                      s1_lcol_ff, s1_lrow_ff;
   logic                      s1_adv, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff   <= req_pixel_in;
         s1_prev1_ff <= prev1_ff;
         s1_prev2_ff <= prev2_ff;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_lcol_ff  <= last_col;
         s1_lrow_ff  <= last_row;
      end
   end

   // horizontal results: q_prev for column c-1, q_cur for column c (row end)
   logic [9:0]                hs3;
   logic [8:0]                hs2;
   logic [sbb_pkg::PIX_W-1:0] q_prev, q_cur;
   logic                      s1_c_ge1, s1_c_is1, s1_r_ge1, s1_r_is1;

   assign s1_c_ge1 = (s1_col_ff != '0);
   assign s1_c_is1 = (s1_col_ff == ColW'(1));
   assign s1_r_ge1 = (s1_row_ff != '0);
   assign s1_r_is1 = (s1_row_ff == sbb_pkg::ROW_W'(1));

   assign hs3    = 10'(s1_prev2_ff) + 10'({s1_prev1_ff, 1'b0}) + 10'(s1_pix_ff) + 10'd2;
   assign hs2    = 9'(s1_prev1_ff) + 9'(s1_pix_ff) + 9'd1;
   assign q_cur  = hs2[8:1];
   assign q_prev = s1_c_is1 ? hs2[8:1] : hs3[9:2];

   // entries of columns c-1 and c
   logic [sbb_pkg::PAIR_W-1:0] pair_prev, pair_cur;
   logic [sbb_pkg::PIX_W-1:0]  old_prev, new_prev, old_cur, new_cur;

   assign pair_prev = s1_col_ff[0] ? rd_data0 : rd_data1;
   assign pair_cur  = s1_col_ff[0] ? rd_data1 : rd_data0;
   assign old_prev  = pair_prev[sbb_pkg::PAIR_W-1:sbb_pkg::PIX_W];
   assign new_prev  = pair_prev[sbb_pkg::PIX_W-1:0];
   assign old_cur   = pair_cur[sbb_pkg::PAIR_W-1:sbb_pkg::PIX_W];
   assign new_cur   = pair_cur[sbb_pkg::PIX_W-1:0];

   // up to four results, in column order, upper row first
   logic [ColExtW-1:0]         col_ext, col_ext_m1;
   logic [sbb_pkg::ROW_W-1:0]  row_m1;
   sbb_pkg::result_type        e0, e1, e2, e3;
   sbb_pkg::result_type        slot [sbb_pkg::OB_DEPTH];
   logic                       v0, v1, v2, v3;
   logic [sbb_pkg::OB_CNT_W-1:0] s1_cnt;

   assign col_ext    = ColExtW'(s1_col_ff);
   assign col_ext_m1 = col_ext - ColExtW'(1);
   assign row_m1     = s1_row_ff - sbb_pkg::ROW_W'(1);

   always_comb begin
      v0 = s1_c_ge1 && s1_r_ge1;
      v1 = v0 && s1_lrow_ff;
      v2 = v0 && s1_lcol_ff;
      v3 = v2 && s1_lrow_ff;

      e0.pixel = vert_upper(old_prev, new_prev, q_prev, s1_r_is1);
      e0.col   = col_ext_m1[sbb_pkg::COL_OUT_W-1:0];
      e0.row   = row_m1;
      e1.pixel = vert_bottom(new_prev, q_prev);
      e1.col   = col_ext_m1[sbb_pkg::COL_OUT_W-1:0];
      e1.row   = s1_row_ff;
      e2.pixel = vert_upper(old_cur, new_cur, q_cur, s1_r_is1);
      e2.col   = col_ext[sbb_pkg::COL_OUT_W-1:0];
      e2.row   = row_m1;
      e3.pixel = vert_bottom(new_cur, q_cur);
      e3.col   = col_ext[sbb_pkg::COL_OUT_W-1:0];
      e3.row   = s1_row_ff;

      // valid patterns are {}, {0}, {0,1}, {0,2}, {0,1,2,3}
      slot[0] = e0;
      slot[1] = v1 ? e1 : e2;
      slot[2] = e2;
      slot[3] = e3;
      s1_cnt  = sbb_pkg::OB_CNT_W'(v0) + sbb_pkg::OB_CNT_W'(v1)
              + sbb_pkg::OB_CNT_W'(v2) + sbb_pkg::OB_CNT_W'(v3);
   end

   // line store write-back as stage 1 leaves
   logic                       wr_en0, wr_en1;
   logic [BankAw-1:0]          wr_addr0, wr_addr1;
   logic [sbb_pkg::PAIR_W-1:0] wr_data0, wr_data1;
   logic [ColW-1:0]            s1_col_m1;

   assign s1_col_m1 = s1_col_ff - ColW'(1);
   assign wr_en0    = s1_adv && s1_c_ge1 && (s1_col_ff[0] || s1_lcol_ff);
   assign wr_en1    = s1_adv && s1_c_ge1 && (!s1_col_ff[0] || s1_lcol_ff);
   assign wr_addr0  = s1_col_ff[0] ? BankAw'(s1_col_m1 >> 1) : BankAw'(s1_col_ff >> 1);
   assign wr_addr1  = s1_col_ff[0] ? BankAw'(s1_col_ff >> 1) : BankAw'(s1_col_m1 >> 1);
   assign wr_data0  = s1_col_ff[0] ? {new_prev, q_prev} : {new_cur, q_cur};
   assign wr_data1  = s1_col_ff[0] ? {new_cur, q_cur} : {new_prev, q_prev};

   sbb_line_bank #(
      .DEPTH  (BankDepth),
      .ADDR_W (BankAw)
   ) u_bank_even (
      .clock      (clock),
      .wr_en      (wr_en0),
      .wr_addr    (wr_addr0),
      .wr_data    (wr_data0),
      .rd_en      (req_fire),
      .rd_addr    (rd_addr0),
      .rd_data_ff (rd_data0)
   );

   sbb_line_bank #(
      .DEPTH  (BankDepth),
      .ADDR_W (BankAw)
   ) u_bank_odd (
      .clock      (clock),
      .wr_en      (wr_en1),
      .wr_addr    (wr_addr1),
      .wr_data    (wr_data1),
      .rd_en      (req_fire),
      .rd_addr    (rd_addr1),
      .rd_data_ff (rd_data1)
   );

   // ---------------------------------------------------------------- result buffer
   sbb_pkg::result_type            ob_ff [sbb_pkg::OB_DEPTH];
   logic [sbb_pkg::OB_CNT_W-1:0]   ob_left_ff;
   logic [sbb_pkg::OB_IDX_W-1:0]   ob_idx_ff;
   logic                           rsp_fire;
   sbb_pkg::result_type            ob_head;

   assign rsp_valid = (ob_left_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign out_free  = (ob_left_ff == '0)
                   || ((ob_left_ff == sbb_pkg::OB_CNT_W'(1)) && rsp_ready);
   // transactions with no result retire without touching the buffer
   assign s1_adv    = s1_valid_ff && ((s1_cnt == '0) || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_left_ff <= '0;
         ob_idx_ff  <= '0;
      end else if (s1_adv && (s1_cnt != '0)) begin
         ob_left_ff <= s1_cnt;
         ob_idx_ff  <= '0;
      end else if (rsp_fire) begin
         ob_left_ff <= ob_left_ff - sbb_pkg::OB_CNT_W'(1);
         ob_idx_ff  <= ob_idx_ff + sbb_pkg::OB_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (s1_cnt != '0)) begin
         ob_ff <= slot;
      end
   end

   assign ob_head       = ob_ff[ob_idx_ff];
   assign rsp_pixel_out = ob_head.pixel;
   assign rsp_out_col   = ob_head.col;
   assign rsp_out_row   = ob_head.row;
   assign rsp_run_last  = (ob_left_ff == sbb_pkg::OB_CNT_W'(1));

endmodule

// ===== rtl/core/sbb_checker.sv =====
`include "separable_binomial_blur_defines.svh"

module sbb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sbb_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic [sbb_pkg::COL_OUT_W-1:0]  rsp_out_col,
   input logic [sbb_pkg::ROW_W-1:0]      rsp_out_row,
   input logic                           rsp_run_last
);

   logic mid_burst;

   assign mid_burst = rsp_valid && rsp_ready && !rsp_run_last;

   `SBB_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready, "not idle after reset")

   `SBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_out_col) && $stable(rsp_out_row), "stalled result changed")

   `SBB_ASSERT_NEXT(a_burst_cont, clock, reset, mid_burst, rsp_valid, "result burst broken")

   `SBB_ASSERT_NEXT(a_burst_col, clock, reset, mid_burst, (rsp_out_col == $past(rsp_out_col)) || (rsp_out_col == $past(rsp_out_col) + sbb_pkg::COL_OUT_W'(1)), "burst column jump")

endmodule

bind separable_binomial_blur sbb_checker u_sbb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_row   (rsp_out_row),
   .rsp_run_last  (rsp_run_last)
);

// ===== tb/separable_binomial_blur_test.sv =====
module separable_binomial_blur_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 6;
   localparam int IDLE_PCT       = 24;       // percent of cycles each side sits out
   localparam int DRAIN_CYCLES   = 8;        // pipeline depth plus margin
   localparam int HOLDOFF_CYCLES = 150;      // long receiver stall for backpressure
   localparam int RANDOM_ITEMS   = 100;
   localparam int PREFILL_W      = 16;       // line store columns written up front
   localparam int TIMEOUT_NS     = 5_000_000;

   // one blurred pixel as seen on the rsp channel
   typedef struct packed {
      logic [sbb_pkg::PIX_W-1:0]     pixel;
      logic [sbb_pkg::COL_OUT_W-1:0] col;
      logic [sbb_pkg::ROW_W-1:0]     row;
      logic                          run_last;
   } blur_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid    = 1'b0;
   logic                           req_ready;
   logic [sbb_pkg::PIX_W-1:0]      req_pixel_in = '0;

   logic                           rsp_valid;
   logic                           rsp_ready    = 1'b0;
   logic [sbb_pkg::PIX_W-1:0]      rsp_pixel_out;
   logic [sbb_pkg::COL_OUT_W-1:0]  rsp_out_col;
   logic [sbb_pkg::ROW_W-1:0]      rsp_out_row;
   logic                           rsp_run_last;

   logic                           csr_we       = 1'b0;
   logic [sbb_pkg::CSR_IDX_W-1:0]  csr_addr     = '0;
   logic [sbb_pkg::CSR_DATA_W-1:0] csr_wdata    = '0;

   // stimulus control
   logic [sbb_pkg::PIX_W-1:0] pending_pixels [$];
   bit               steady      = 1'b0;   // no idling on either side
   bit               holdoff_go  = 1'b0;
   logic             rsp_hold    = 1'b0;
   int               mismatch_count = 0;
   int               random_items   = 0;

   // shadow of the block: registers, pixel history, position, line stores
   logic [sbb_pkg::WIDTH_REG_W-1:0]  width_reg  =
      sbb_pkg::WIDTH_REG_W'(sbb_pkg::WIDTH_RESET);
   logic [sbb_pkg::HEIGHT_REG_W-1:0] height_reg =
      sbb_pkg::HEIGHT_REG_W'(sbb_pkg::HEIGHT_RESET);
   int unsigned             prev1 = 0, prev2 = 0;
   int unsigned             col_pos = 0, row_pos = 0;
   logic [sbb_pkg::PIX_W-1:0] hline_older [sbb_pkg::MAX_WIDTH_DEF];
   logic [sbb_pkg::PIX_W-1:0] hline_newer [sbb_pkg::MAX_WIDTH_DEF];
   blur_result_type         predicted_blur [$];

   separable_binomial_blur dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_row  (rsp_out_row),
      .rsp_run_last (rsp_run_last),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void add_blurred(int unsigned val, int unsigned c, int unsigned r);
      blur_result_type res;
      res.pixel    = val[sbb_pkg::PIX_W-1:0];
      res.col      = c[sbb_pkg::COL_OUT_W-1:0];
      res.row      = r[sbb_pkg::ROW_W-1:0];
      res.run_last = 1'b0;
      predicted_blur = {predicted_blur, res};
   endfunction

   // one horizontal result q of column c, row r, enters the vertical stage
   function automatic void vertical_tap(int unsigned c, int unsigned q, int unsigned r,
                                        bit last_row);
      int unsigned a, b;
      a = hline_older[c];
      b = hline_newer[c];
      if (r >= 1) begin
         // top row: rounded 2-tap; inner rows: rounded [1 2 1]
         if (r == 1)
            add_blurred((b + q + 1) >> 1, c, r - 1);
         else
            add_blurred((a + 2 * b + q + 2) >> 2, c, r - 1);
         // bottom row closes with a truncating 2-tap average
         if (last_row)
            add_blurred((b + q) >> 1, c, r);
      end
      hline_older[c] = b[sbb_pkg::PIX_W-1:0];
      hline_newer[c] = q[sbb_pkg::PIX_W-1:0];
   endfunction

   // expected results of one accepted pixel
   function automatic void predict_blur(int unsigned p);
      int unsigned  w, h, c, r, n0;
      bit           last_col, last_row;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > sbb_pkg::MAX_WIDTH_DEF) w = sbb_pkg::MAX_WIDTH_DEF;
      h = height_reg;
      if (h < 2) h = 2;
      if (h > sbb_pkg::HEIGHT_LIMIT) h = sbb_pkg::HEIGHT_LIMIT;
      c  = col_pos;
      r  = row_pos;
      // counters beyond a shrunk geometry count as the last column / row
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      n0 = predicted_blur.size();
      if (c >= 1) begin
         if (c == 1)
            vertical_tap(c - 1, (prev1 + p + 1) >> 1, r, last_row);
         else
            vertical_tap(c - 1, (prev2 + 2 * prev1 + p + 2) >> 2, r, last_row);
         // right edge: rounded 2-tap for the last column itself
         if (last_col)
            vertical_tap(c, (prev1 + p + 1) >> 1, r, last_row);
      end
      prev2 = prev1;
      prev1 = p;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (predicted_blur.size() > n0)
         predicted_blur[predicted_blur.size() - 1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers queued pixels, predicts on each accepted transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_blur(32'(req_pixel_in));
         // payload may only change once the current transaction is taken
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid    <= 1'b1;
               req_pixel_in <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result transaction against the oldest prediction
   // ------------------------------------------------------------------
   function automatic void check_blurred();
      blur_result_type want;
      if (predicted_blur.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: pixel %0d col %0d row %0d last %0b",
                     rsp_pixel_out, rsp_out_col, rsp_out_row, rsp_run_last);
      end else begin
         want = predicted_blur.pop_front();
         if (rsp_pixel_out !== want.pixel || rsp_out_col !== want.col ||
             rsp_out_row !== want.row || rsp_run_last !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"mismatch: expected pixel %0d col %0d row %0d last %0b, ",
                         "got %0d %0d %0d %0b"},
                        want.pixel, want.col, want.row, want.run_last,
                        rsp_pixel_out, rsp_out_col, rsp_out_row, rsp_run_last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_blurred();
         rsp_ready <= !rsp_hold && (steady || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // long receiver stall, counted here so the sender keeps pushing meanwhile
   initial begin : receiver_holdoff
      wait (holdoff_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------

   // everything sent, taken and checked, then let the pipe run dry
   task automatic wait_idle();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || predicted_blur.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register writes only once the block is quiet
   task automatic set_geometry(input bit write_w, input logic [sbb_pkg::CSR_DATA_W-1:0] w_val,
                               input bit write_h, input logic [sbb_pkg::CSR_DATA_W-1:0] h_val);
      wait_idle();
      if (write_w) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= sbb_pkg::CSR_WIDTH;
         csr_wdata <= w_val;
         width_reg  = w_val[sbb_pkg::WIDTH_REG_W-1:0];
      end
      if (write_h) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= sbb_pkg::CSR_HEIGHT;
         csr_wdata <= h_val;
         height_reg = h_val[sbb_pkg::HEIGHT_REG_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random(input int n);
      @(negedge clock);
      repeat (n) pending_pixels = {pending_pixels, sbb_pkg::PIX_W'($urandom_range(255))};
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [sbb_pkg::CSR_DATA_W-1:0] w_val, h_val;
      bit                    do_w, do_h;
      int                    n, phase;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Two full rows over the first PREFILL_W columns. Every column used
      // later stays below PREFILL_W, so geometry changes never hit unwritten
      // line store entries.
      set_geometry(1'b1, 13'(PREFILL_W), 1'b1, 13'd2);
      send_random(2 * PREFILL_W);

      // smallest image, pixel extremes and rounding
      set_geometry(1'b1, 13'd2, 1'b1, 13'd2);
      @(negedge clock);
      pending_pixels = {pending_pixels, 8'd255, 8'd0, 8'd0, 8'd255};

      // both registers at zero clamp to 2 x 2
      set_geometry(1'b1, 13'd0, 1'b1, 13'd0);
      @(negedge clock);
      pending_pixels = {pending_pixels, 8'd255, 8'd255, 8'd255, 8'd255};

      // oversized width clamps to the line length; then the width shrinks
      // mid-row: column already past the new edge ends the row
      set_geometry(1'b1, 13'd2047, 1'b1, 13'd4096);
      send_random(7);
      set_geometry(1'b1, 13'd1, 1'b0, '0);
      send_random(1);
      // height shrinks mid-image: current row becomes the bottom row and wraps
      set_geometry(1'b0, '0, 1'b1, 13'd2);
      send_random(2);

      // width grows mid-image; width value carries bits above the register
      set_geometry(1'b1, 13'd3, 1'b1, 13'd8191);
      send_random(4);
      set_geometry(1'b1, 13'h1806, 1'b0, '0);
      send_random(5);

      // random geometry and content; widths stay within the prefilled columns
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0:       w_val = sbb_pkg::CSR_DATA_W'(($urandom_range(3) << sbb_pkg::WIDTH_REG_W)
                                                  | $urandom_range(2, PREFILL_W));
            1:       w_val = sbb_pkg::CSR_DATA_W'($urandom_range(1));
            default: w_val = sbb_pkg::CSR_DATA_W'($urandom_range(2, 8));
         endcase
         case ($urandom_range(9))
            0:       h_val = sbb_pkg::CSR_DATA_W'($urandom_range(8191));
            1:       h_val = sbb_pkg::CSR_DATA_W'($urandom_range(1));
            default: h_val = sbb_pkg::CSR_DATA_W'($urandom_range(2, 5));
         endcase
         do_w = ($urandom_range(3) != 0);
         do_h = ($urandom_range(3) != 0);
         n    = $urandom_range(4, 24);
         if (phase == 1 || phase == 3) begin
            do_w  = 1'b1;
            do_h  = 1'b1;
            w_val = 13'd4;
            h_val = 13'd3;
            n     = 40;
         end
         set_geometry(do_w, w_val, do_h, h_val);
         @(negedge clock);
         steady = (phase == 1);          // back-to-back stretch on both sides
         if (phase == 3)
            holdoff_go = 1'b1;            // receiver stalls while pixels keep coming
         send_random(n);
         random_items += n;
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sbb_pkg.sv
rtl/core/sbb_line_bank.sv
rtl/core/separable_binomial_blur.sv
rtl/core/sbb_checker.sv
tb/separable_binomial_blur_test.sv
